// ----- rtl/vli_pkg.sv -----
// vli_pkg: shared constants for the vertex light interpolator
// no dependencies; used by the channel interfaces, the divider and the top level
package vli_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int LIGHT_BITS     = 17;
  localparam int OUT_BITS       = 16;
  localparam int CORNERS        = 4;

  localparam logic [OUT_BITS-1:0] LIGHT_MAX = 16'd65280;

  // corner offsets, bit k belongs to corner k (a, b, c, d)
  localparam logic [CORNERS-1:0] CORNER_OU = 4'b0110;
  localparam logic [CORNERS-1:0] CORNER_OV = 4'b1100;

  // divider defaults
  localparam int DIV_LANES_DEF  = 2;
  localparam int DIV_NUM_W_DEF  = COORD_BITS_DEF + FRAC_BITS_DEF;
  localparam int DIV_QUOT_W_DEF = FRAC_BITS_DEF + 2;
  localparam int DIV_SIDE_W_DEF = 3 + CORNERS * LIGHT_BITS;

endpackage

// ----- rtl/vli_in_if.sv -----
// vli_in_if: input channel of the vertex light interpolator (position, box, corner lights)
// depends on vli_pkg
interface vli_in_if import vli_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_y;
  logic signed [COORD_BITS-1:0]  box_min_x;
  logic signed [COORD_BITS-1:0]  box_max_x;
  logic signed [COORD_BITS-1:0]  box_min_y;
  logic signed [COORD_BITS-1:0]  box_max_y;
  logic signed [LIGHT_BITS-1:0]  corner_light_a;
  logic signed [LIGHT_BITS-1:0]  corner_light_b;
  logic signed [LIGHT_BITS-1:0]  corner_light_c;
  logic signed [LIGHT_BITS-1:0]  corner_light_d;

  modport source (
    output valid, pos_x, pos_y, box_min_x, box_max_x, box_min_y, box_max_y,
    output corner_light_a, corner_light_b, corner_light_c, corner_light_d,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, box_min_x, box_max_x, box_min_y, box_max_y,
    input  corner_light_a, corner_light_b, corner_light_c, corner_light_d,
    output ready
  );
endinterface

// ----- rtl/vli_out_if.sv -----
// vli_out_if: result channel of the vertex light interpolator
// depends on vli_pkg
interface vli_out_if import vli_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] vertex_light;
  logic                box_degenerate;

  modport source (output valid, vertex_light, box_degenerate, input ready);
  modport sink (input valid, vertex_light, box_degenerate, output ready);
endinterface

// ----- rtl/vli_div_pipe.sv -----
// vli_div_pipe: pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on vli_pkg; carries a sideband word in step with the quotient
module vli_div_pipe import vli_pkg::*; #(
  parameter int LANES = DIV_LANES_DEF,
  parameter int N_W   = DIV_NUM_W_DEF,
  parameter int D_W   = COORD_BITS_DEF,
  parameter int Q_W   = DIV_QUOT_W_DEF,
  parameter int S_W   = DIV_SIDE_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [LANES-1:0][N_W-1:0]   in_num,
  input  logic [LANES-1:0][D_W-1:0]   in_den,
  input  logic [S_W-1:0]              in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [LANES-1:0][Q_W-1:0]   out_quot,
  output logic [LANES-1:0]            out_over,
  output logic [S_W-1:0]              out_side
);

  localparam int R_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [Q_W:0]                vld;
  logic [Q_W:0]                en;
  logic [LANES-1:0][R_W-1:0]   rem  [Q_W+1];
  logic [LANES-1:0][D_W-1:0]   den  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   quot [Q_W+1];
  logic [LANES-1:0]            over [Q_W+1];
  logic [S_W-1:0]              side [Q_W+1];

  assign in_ready  = en[0];
  assign out_valid = vld[Q_W];
  assign out_quot  = quot[Q_W];
  assign out_over  = over[Q_W];
  assign out_side  = side[Q_W];

  genvar s;
  generate
    for (s = 0; s <= Q_W; s++) begin : g_en
      if (s == Q_W) begin : g_last
        assign en[s] = !vld[s] || out_ready;
      end else begin : g_mid
        assign en[s] = !vld[s] || en[s+1];
      end
    end
  endgenerate

  // entry stage: operands and overflow check
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l]  <= R_W'(in_num[l]);
        den[0][l]  <= in_den[l];
        over[0][l] <= R_W'(in_num[l]) >= (R_W'(in_den[l]) << Q_W);
        quot[0][l] <= '0;
      end
      side[0] <= in_side;
    end
  end

  // one quotient bit per stage, msb first
  generate
    for (s = 1; s <= Q_W; s++) begin : g_step
      localparam int B = Q_W - s;
      logic [LANES-1:0][R_W-1:0] dsh;
      logic [LANES-1:0][R_W-1:0] rem_next;
      logic [LANES-1:0][Q_W-1:0] quot_next;

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          dsh[l]       = R_W'(den[s-1][l]) << B;
          quot_next[l] = quot[s-1][l];
          if (rem[s-1][l] >= dsh[l]) begin
            rem_next[l]     = rem[s-1][l] - dsh[l];
            quot_next[l][B] = 1'b1;
          end else begin
            rem_next[l] = rem[s-1][l];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem[s]  <= rem_next;
          den[s]  <= den[s-1];
          quot[s] <= quot_next;
          over[s] <= over[s-1];
          side[s] <= side[s-1];
        end
      end
    end
  endgenerate

endmodule

// ----- rtl/vertex_light_interpolator.sv -----
// vertex_light_interpolator: interpolates a vertex light from four tile corner lights
// channels: item (vli_in_if.sink) carries position, box and lights; result (vli_out_if.source)
// carries vertex_light (Q8.8, clamped to 0..255) and box_degenerate.
// both channels move a beat at a clock edge where valid and ready are high.
// one beat in, one beat out, in order; a new item can enter every cycle (1 item/cycle)
// while result.ready is high. the pipe is made of the two bit-per-stage dividers:
// FRAC_BITS + 3 stages for u and v, 17 stages for the final quotient,
// plus 11 stages for differences, saturation, squares, weights, products and sums.
// every stage has its own valid bit; a stage loads when it is empty or the next one moves,
// so bubbles close up and input is still taken while a finished result waits.
// when the receiver holds result.ready low, the pipe fills and then item.ready drops;
// nothing is lost or repeated.
// rst (synchronous, active high) empties the pipe; no clearing pass, ready right after.
// a box of zero width or height gives box_degenerate = 1 and vertex_light = 0.
// depends on vli_pkg, vli_in_if, vli_out_if and vli_div_pipe
module vertex_light_interpolator import vli_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vli_in_if.sink     item,
  vli_out_if.source  result
);

  localparam int QU_W  = FRAC_BITS + 2;
  localparam int U_W   = FRAC_BITS + 3;
  localparam int DQ_W  = FRAC_BITS + 2;
  localparam int SQ_W  = FRAC_BITS + 1;
  localparam int P_W   = 2 * FRAC_BITS + 2;
  localparam int DP_W  = 2 * DQ_W;
  localparam int W_W   = FRAC_BITS + 1;
  localparam int LW_W  = W_W + 1 + LIGHT_BITS;
  localparam int LP_W  = LW_W + 1;
  localparam int LS_W  = LW_W + 2;
  localparam int WP_W  = W_W + 1;
  localparam int WS_W  = W_W + 2;
  localparam int N1_W  = COORD_BITS + FRAC_BITS;
  localparam int S1_W  = 3 + CORNERS * LIGHT_BITS;
  localparam int N2_W  = LS_W - 1;

  localparam logic [QU_W-1:0]       QU_TWO   = QU_W'(2 << FRAC_BITS);
  localparam logic [QU_W-1:0]       QU_THREE = QU_W'(3 << FRAC_BITS);
  localparam logic signed [U_W-1:0] U_ONE    = U_W'(1 << FRAC_BITS);
  localparam logic [SQ_W-1:0]       SQ_ONE   = SQ_W'(1 << FRAC_BITS);

  // stage a: differences
  logic                                a_vld, a_en;
  logic signed [COORD_BITS:0]          a_nx, a_dx, a_ny, a_dy;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  a_light;

  // stage b: magnitudes and signs
  logic                                b_vld, b_en;
  logic [1:0][COORD_BITS-1:0]          b_an, b_ad;
  logic [1:0]                          b_neg;
  logic                                b_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  b_light;
  logic [COORD_BITS:0]                 b_anx, b_adx, b_any, b_ady;

  // first divider
  logic                                d1_in_ready, d1_out_valid;
  logic [1:0][N1_W-1:0]                d1_num;
  logic [S1_W-1:0]                     d1_side_in, d1_side;
  logic [1:0][QU_W-1:0]                d1_quot;
  logic [1:0]                          d1_over;
  logic [1:0]                          d1_neg;
  logic                                d1_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  d1_light;

  // stage c: saturated u and v
  logic                                c_vld, c_en;
  logic signed [U_W-1:0]               c_u [2];
  logic signed [U_W-1:0]               c_u_next [2];
  logic [1:0][QU_W-1:0]                c_mag;
  logic                                c_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  c_light;

  // stage e: offsets from the corners, range flags
  logic                                e_vld, e_en;
  logic signed [U_W-1:0]               e_full [4];
  logic signed [DQ_W-1:0]              e_d [4];
  logic [3:0]                          e_in, e_in_next;
  logic                                e_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  e_light;

  // stage f: squares
  logic                                f_vld, f_en;
  logic signed [DP_W-1:0]              f_prod [4];
  logic [SQ_W-1:0]                     f_sq [4];
  logic [3:0]                          f_in;
  logic                                f_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  f_light;

  // stage g: axis weights
  logic                                g_vld, g_en;
  logic [SQ_W-1:0]                     g_aw [4];
  logic [3:0]                          g_in;
  logic                                g_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  g_light;

  // stage h: corner weights
  logic                                h_vld, h_en;
  logic [P_W-1:0]                      h_prod [CORNERS];
  logic [W_W-1:0]                      h_w [CORNERS];
  logic [W_W-1:0]                      h_w_next [CORNERS];
  logic                                h_degen;
  logic [CORNERS-1:0][LIGHT_BITS-1:0]  h_light;

  // stage i: weighted lights
  logic                                i_vld, i_en;
  logic signed [LW_W-1:0]              i_lw [CORNERS];
  logic [W_W-1:0]                      i_w [CORNERS];
  logic                                i_degen;

  // stage j: pair sums
  logic                                j_vld, j_en;
  logic signed [LP_W-1:0]              j_ls [2];
  logic [WP_W-1:0]                     j_ws [2];
  logic                                j_degen;

  // stage k: totals
  logic                                k_vld, k_en;
  logic signed [LS_W-1:0]              k_ls;
  logic [WS_W-1:0]                     k_ws;
  logic                                k_degen;
  logic                                k_pos;

  // second divider
  logic                                d2_in_ready, d2_out_valid;
  logic [0:0][N2_W-1:0]                d2_num;
  logic [0:0][WS_W-1:0]                d2_den;
  logic [0:0][OUT_BITS-1:0]            d2_quot;
  logic [0:0]                          d2_over;
  logic [1:0]                          d2_side;

  // output register
  logic                                o_vld, o_en;
  logic [OUT_BITS-1:0]                 o_light, o_light_next;
  logic                                o_degen;

  // stage enables
  assign a_en = !a_vld || b_en;
  assign b_en = !b_vld || d1_in_ready;
  assign c_en = !c_vld || e_en;
  assign e_en = !e_vld || f_en;
  assign f_en = !f_vld || g_en;
  assign g_en = !g_vld || h_en;
  assign h_en = !h_vld || i_en;
  assign i_en = !i_vld || j_en;
  assign j_en = !j_vld || k_en;
  assign k_en = !k_vld || d2_in_ready;
  assign o_en = !o_vld || result.ready;

  assign item.ready            = a_en;
  assign result.valid          = o_vld;
  assign result.vertex_light   = o_light;
  assign result.box_degenerate = o_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
      i_vld <= 1'b0;
      j_vld <= 1'b0;
      k_vld <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      if (a_en) a_vld <= item.valid;
      if (b_en) b_vld <= a_vld;
      if (c_en) c_vld <= d1_out_valid;
      if (e_en) e_vld <= c_vld;
      if (f_en) f_vld <= e_vld;
      if (g_en) g_vld <= f_vld;
      if (h_en) h_vld <= g_vld;
      if (i_en) i_vld <= h_vld;
      if (j_en) j_vld <= i_vld;
      if (k_en) k_vld <= j_vld;
      if (o_en) o_vld <= d2_out_valid;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_nx <= $signed({item.pos_x[COORD_BITS-1], item.pos_x})
            - $signed({item.box_min_x[COORD_BITS-1], item.box_min_x});
      a_dx <= $signed({item.box_max_x[COORD_BITS-1], item.box_max_x})
            - $signed({item.box_min_x[COORD_BITS-1], item.box_min_x});
      a_ny <= $signed({item.pos_y[COORD_BITS-1], item.pos_y})
            - $signed({item.box_min_y[COORD_BITS-1], item.box_min_y});
      a_dy <= $signed({item.box_max_y[COORD_BITS-1], item.box_max_y})
            - $signed({item.box_min_y[COORD_BITS-1], item.box_min_y});
      a_light[0] <= item.corner_light_a;
      a_light[1] <= item.corner_light_b;
      a_light[2] <= item.corner_light_c;
      a_light[3] <= item.corner_light_d;
    end
  end

  // stage b
  always_comb begin
    b_anx = a_nx[COORD_BITS] ? -a_nx : a_nx;
    b_adx = a_dx[COORD_BITS] ? -a_dx : a_dx;
    b_any = a_ny[COORD_BITS] ? -a_ny : a_ny;
    b_ady = a_dy[COORD_BITS] ? -a_dy : a_dy;
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_an[0]  <= b_anx[COORD_BITS-1:0];
      b_ad[0]  <= b_adx[COORD_BITS-1:0];
      b_an[1]  <= b_any[COORD_BITS-1:0];
      b_ad[1]  <= b_ady[COORD_BITS-1:0];
      b_neg[0] <= a_nx[COORD_BITS] ^ a_dx[COORD_BITS];
      b_neg[1] <= a_ny[COORD_BITS] ^ a_dy[COORD_BITS];
      b_degen  <= (a_dx == '0) || (a_dy == '0);
      b_light  <= a_light;
    end
  end

  // u and v: |pos - min| << FRAC_BITS over |max - min|
  assign d1_num[0]  = {b_an[0], {FRAC_BITS{1'b0}}};
  assign d1_num[1]  = {b_an[1], {FRAC_BITS{1'b0}}};
  assign d1_side_in = {b_neg, b_degen, b_light};
  assign {d1_neg, d1_degen, d1_light} = d1_side;

  vli_div_pipe #(
    .LANES (2),
    .N_W   (N1_W),
    .D_W   (COORD_BITS),
    .Q_W   (QU_W),
    .S_W   (S1_W)
  ) u_div_coord (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_vld),
    .in_ready  (d1_in_ready),
    .in_num    (d1_num),
    .in_den    (b_ad),
    .in_side   (d1_side_in),
    .out_valid (d1_out_valid),
    .out_ready (c_en),
    .out_quot  (d1_quot),
    .out_over  (d1_over),
    .out_side  (d1_side)
  );

  // stage c: saturate to [-2, 3]
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (d1_neg[l]) begin
        c_mag[l]    = (d1_over[l] || d1_quot[l] > QU_TWO) ? QU_TWO : d1_quot[l];
        c_u_next[l] = -$signed({1'b0, c_mag[l]});
      end else begin
        c_mag[l]    = (d1_over[l] || d1_quot[l] > QU_THREE) ? QU_THREE : d1_quot[l];
        c_u_next[l] = $signed({1'b0, c_mag[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_u     <= c_u_next;
      c_degen <= d1_degen;
      c_light <= d1_light;
    end
  end

  // stage e: order is u, u - 1, v, v - 1
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e_full[i]    = c_u[i[1]] - (i[0] ? U_ONE : '0);
      e_in_next[i] = (e_full[i] >= -U_ONE) && (e_full[i] <= U_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      for (int i = 0; i < 4; i++) begin
        e_d[i] <= e_full[i][DQ_W-1:0];
      end
      e_in    <= e_in_next;
      e_degen <= c_degen;
      e_light <= c_light;
    end
  end

  // stage f
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f_prod[i] = e_d[i] * e_d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      for (int i = 0; i < 4; i++) begin
        f_sq[i] <= f_prod[i][2*FRAC_BITS:FRAC_BITS];
      end
      f_in    <= e_in;
      f_degen <= e_degen;
      f_light <= e_light;
    end
  end

  // stage g
  always_ff @(posedge clk) begin
    if (g_en) begin
      for (int i = 0; i < 4; i++) begin
        g_aw[i] <= SQ_ONE - f_sq[i];
      end
      g_in    <= f_in;
      g_degen <= f_degen;
      g_light <= f_light;
    end
  end

  // stage h
  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      h_prod[k]   = g_aw[{1'b0, CORNER_OU[k]}] * g_aw[{1'b1, CORNER_OV[k]}];
      h_w_next[k] = (g_in[{1'b0, CORNER_OU[k]}] && g_in[{1'b1, CORNER_OV[k]}])
                  ? h_prod[k][2*FRAC_BITS:FRAC_BITS] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (h_en) begin
      h_w     <= h_w_next;
      h_degen <= g_degen;
      h_light <= g_light;
    end
  end

  // stage i
  always_ff @(posedge clk) begin
    if (i_en) begin
      for (int k = 0; k < CORNERS; k++) begin
        i_lw[k] <= $signed({1'b0, h_w[k]}) * $signed(h_light[k]);
      end
      i_w     <= h_w;
      i_degen <= h_degen;
    end
  end

  // stage j
  always_ff @(posedge clk) begin
    if (j_en) begin
      for (int p = 0; p < 2; p++) begin
        j_ls[p] <= LP_W'(i_lw[2*p]) + LP_W'(i_lw[2*p+1]);
        j_ws[p] <= WP_W'(i_w[2*p]) + WP_W'(i_w[2*p+1]);
      end
      j_degen <= i_degen;
    end
  end

  // stage k
  always_ff @(posedge clk) begin
    if (k_en) begin
      k_ls    <= LS_W'(j_ls[0]) + LS_W'(j_ls[1]);
      k_ws    <= WS_W'(j_ws[0]) + WS_W'(j_ws[1]);
      k_degen <= j_degen;
    end
  end

  // light sum over weight sum
  assign k_pos     = !k_ls[LS_W-1] && (k_ls != '0) && (k_ws != '0);
  assign d2_num[0] = k_ls[N2_W-1:0];
  assign d2_den[0] = k_ws;

  vli_div_pipe #(
    .LANES (1),
    .N_W   (N2_W),
    .D_W   (WS_W),
    .Q_W   (OUT_BITS),
    .S_W   (2)
  ) u_div_light (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (k_vld),
    .in_ready  (d2_in_ready),
    .in_num    (d2_num),
    .in_den    (d2_den),
    .in_side   ({k_degen, k_pos}),
    .out_valid (d2_out_valid),
    .out_ready (o_en),
    .out_quot  (d2_quot),
    .out_over  (d2_over),
    .out_side  (d2_side)
  );

  // output stage: clamp and zero cases
  always_comb begin
    if (d2_side[1] || !d2_side[0]) begin
      o_light_next = '0;
    end else if (d2_over[0] || d2_quot[0] > LIGHT_MAX) begin
      o_light_next = LIGHT_MAX;
    end else begin
      o_light_next = d2_quot[0];
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o_light <= o_light_next;
      o_degen <= d2_side[1];
    end
  end

endmodule

// ----- tb/vertex_light_interpolator_tb.sv -----
`timescale 1ns / 100ps
// vertex_light_interpolator_tb: self-checking bench that streams vertices with boxes and corner
// lights, predicts each light and checks every result beat in order; depends on vli_pkg,
// vli_in_if, vli_out_if and the vertex_light_interpolator top level
module vertex_light_interpolator_tb;
  import vli_pkg::*;

  localparam longint FIX_ONE      = longint'(1) << FRAC_BITS_DEF;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     RANDOM_BURST = 200;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0]      pos_x;
    logic signed [COORD_BITS_DEF-1:0]      pos_y;
    logic signed [COORD_BITS_DEF-1:0]      box_min_x;
    logic signed [COORD_BITS_DEF-1:0]      box_max_x;
    logic signed [COORD_BITS_DEF-1:0]      box_min_y;
    logic signed [COORD_BITS_DEF-1:0]      box_max_y;
    logic [CORNERS-1:0][LIGHT_BITS-1:0]    light;
  } vertex_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] light;
    logic                degenerate;
  } vertex_result_t;

  logic clk;
  logic rst;

  vli_in_if #(.COORD_BITS(COORD_BITS_DEF)) item_ch ();
  vli_out_if result_ch ();

  vertex_light_interpolator #(
    .COORD_BITS(COORD_BITS_DEF),
    .FRAC_BITS (FRAC_BITS_DEF)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch.sink),
    .result(result_ch.source)
  );

  vertex_item_t   pending_vertices[$];
  vertex_result_t expected_lights[$];
  vertex_item_t   cur_vertex;
  vertex_result_t want;
  idle_mode_t     idle_mode;
  int             vertices_queued;
  int             vertices_sent;
  int             results_checked;
  int             errors;
  int             cycle_count;
  int             seen_degenerate;
  int             seen_clamped;
  int             seen_zero;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint norm_axis(longint num, longint den);
    longint an;
    longint ad;
    longint q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an <<< FRAC_BITS_DEF) / ad;
    if ((num < 0) != (den < 0))
      return (q > 2 * FIX_ONE) ? -2 * FIX_ONE : -q;
    return (q > 3 * FIX_ONE) ? 3 * FIX_ONE : q;
  endfunction

  function automatic vertex_result_t interpolate_light(vertex_item_t it);
    longint wx, wy, u, v, du, dv, wu, wv, w, lsum, wsum, q;
    vertex_result_t r;
    wx = longint'(it.box_max_x) - longint'(it.box_min_x);
    wy = longint'(it.box_max_y) - longint'(it.box_min_y);
    r.light = '0;
    r.degenerate = 1'b0;
    if (wx == 0 || wy == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    u = norm_axis(longint'(it.pos_x) - longint'(it.box_min_x), wx);
    v = norm_axis(longint'(it.pos_y) - longint'(it.box_min_y), wy);
    lsum = 0;
    wsum = 0;
    for (int k = 0; k < CORNERS; k++) begin
      du = u - (CORNER_OU[k] ? FIX_ONE : 0);
      dv = v - (CORNER_OV[k] ? FIX_ONE : 0);
      if (du <= FIX_ONE && du >= -FIX_ONE && dv <= FIX_ONE && dv >= -FIX_ONE) begin
        wu = FIX_ONE - ((du * du) >>> FRAC_BITS_DEF);
        wv = FIX_ONE - ((dv * dv) >>> FRAC_BITS_DEF);
        w = (wu * wv) >>> FRAC_BITS_DEF;
        wsum += w;
        lsum += w * longint'($signed(it.light[k]));
      end
    end
    if (lsum > 0 && wsum > 0) begin
      q = lsum / wsum;
      if (q > longint'(LIGHT_MAX))
        q = longint'(LIGHT_MAX);
      r.light = q[OUT_BITS-1:0];
    end
    return r;
  endfunction

  function automatic bit sender_pause(idle_mode_t m);
    int pct;
    pct = (m == IDLE_SENDER) ? 74 : (m == IDLE_BOTH) ? 25 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit receiver_pause(idle_mode_t m);
    int pct;
    pct = (m == IDLE_RECEIVER) ? 74 : (m == IDLE_BOTH) ? 25 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic int rand_light();
    int r;
    r = $urandom_range(99);
    if (r < 10)
      return 0;
    if (r < 80)
      return $urandom_range(65535);
    return int'($urandom());
  endfunction

  task automatic add_vertex(input int px, input int py, input int x0, input int x1,
                            input int y0, input int y1, input int la, input int lb,
                            input int lc, input int ld);
    vertex_item_t it;
    it.pos_x     = px[COORD_BITS_DEF-1:0];
    it.pos_y     = py[COORD_BITS_DEF-1:0];
    it.box_min_x = x0[COORD_BITS_DEF-1:0];
    it.box_max_x = x1[COORD_BITS_DEF-1:0];
    it.box_min_y = y0[COORD_BITS_DEF-1:0];
    it.box_max_y = y1[COORD_BITS_DEF-1:0];
    it.light[0]  = la[LIGHT_BITS-1:0];
    it.light[1]  = lb[LIGHT_BITS-1:0];
    it.light[2]  = lc[LIGHT_BITS-1:0];
    it.light[3]  = ld[LIGHT_BITS-1:0];
    pending_vertices.push_back(it);
    vertices_queued++;
  endtask

  function automatic longint rand_offset(longint w);
    int r;
    r = $urandom_range(99);
    if (r < 4)
      return 0;
    if (r < 8)
      return w;
    if (r < 12)
      return w / 2;
    return longint'($urandom_range(int'(2 * w))) - w / 2;
  endfunction

  task automatic add_random_vertex();
    int     kind;
    longint x0, y0, wx, wy, px, py;
    kind = $urandom_range(99);
    if (kind < 10) begin
      add_vertex(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                 int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                 int'($urandom()), int'($urandom()));
      return;
    end
    wx = 1 + longint'($urandom_range((1 << $urandom_range(22)) - 1));
    wy = 1 + longint'($urandom_range((1 << $urandom_range(22)) - 1));
    x0 = longint'($urandom_range((1 << 23) - 1)) - (1 << 22);
    y0 = longint'($urandom_range((1 << 23) - 1)) - (1 << 22);
    px = x0 + rand_offset(wx);
    py = y0 + rand_offset(wy);
    if (kind < 15) begin
      if ($urandom_range(1))
        wx = 0;
      else
        wy = 0;
    end else if (kind < 23) begin
      if ($urandom_range(1)) begin
        px = x0 + wx - (px - x0);
        wx = -wx;
      end else begin
        py = y0 + wy - (py - y0);
        wy = -wy;
      end
    end
    add_vertex(int'(px), int'(py), int'(x0), int'(x0 + wx), int'(y0), int'(y0 + wy),
               rand_light(), rand_light(), rand_light(), rand_light());
  endtask

  task automatic run_random(input idle_mode_t m, input int n);
    idle_mode = m;
    repeat (n) add_random_vertex();
    while (vertices_sent != vertices_queued) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_lights.push_back(interpolate_light(cur_vertex));
        vertices_sent++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_vertices.size() > 0 && !sender_pause(idle_mode)) begin
          cur_vertex = pending_vertices.pop_front();
          item_ch.pos_x          <= cur_vertex.pos_x;
          item_ch.pos_y          <= cur_vertex.pos_y;
          item_ch.box_min_x      <= cur_vertex.box_min_x;
          item_ch.box_max_x      <= cur_vertex.box_max_x;
          item_ch.box_min_y      <= cur_vertex.box_min_y;
          item_ch.box_max_y      <= cur_vertex.box_max_y;
          item_ch.corner_light_a <= cur_vertex.light[0];
          item_ch.corner_light_b <= cur_vertex.light[1];
          item_ch.corner_light_c <= cur_vertex.light[2];
          item_ch.corner_light_d <= cur_vertex.light[3];
          item_ch.valid          <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_lights.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: light=%0d degenerate=%0b",
                   $time, result_ch.vertex_light, result_ch.box_degenerate);
        end else begin
          want = expected_lights.pop_front();
          results_checked++;
          if (want.degenerate)
            seen_degenerate++;
          else if (want.light == LIGHT_MAX)
            seen_clamped++;
          else if (want.light == '0)
            seen_zero++;
          if (result_ch.vertex_light !== want.light) begin
            errors++;
            $display("%0t: vertex_light expected %0d, got %0d", $time, want.light,
                     result_ch.vertex_light);
          end
          if (result_ch.box_degenerate !== want.degenerate) begin
            errors++;
            $display("%0t: box_degenerate expected %0b, got %0b", $time,
                     want.degenerate, result_ch.box_degenerate);
          end
        end
      end
      result_ch.ready <= !receiver_pause(idle_mode);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_lights.size());
      $display("[vertex_light_interpolator] ERROR");
      $finish;
    end
  end

  initial begin
    rst                    = 1'b1;
    idle_mode              = IDLE_NONE;
    cycle_count            = 0;
    vertices_queued        = 0;
    vertices_sent          = 0;
    results_checked        = 0;
    errors                 = 0;
    seen_degenerate        = 0;
    seen_clamped           = 0;
    seen_zero              = 0;
    item_ch.valid          = 1'b0;
    item_ch.pos_x          = '0;
    item_ch.pos_y          = '0;
    item_ch.box_min_x      = '0;
    item_ch.box_max_x      = '0;
    item_ch.box_min_y      = '0;
    item_ch.box_max_y      = '0;
    item_ch.corner_light_a = '0;
    item_ch.corner_light_b = '0;
    item_ch.corner_light_c = '0;
    item_ch.corner_light_d = '0;
    result_ch.ready        = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // vertex on each corner of a 1024-by-1024 box
    add_vertex(0, 0, 0, 1024, 0, 1024, 65535, 0, 0, 0);
    add_vertex(1024, 0, 0, 1024, 0, 1024, 0, 25600, 0, 0);
    add_vertex(1024, 1024, 0, 1024, 0, 1024, 0, 0, -65536, 12800);
    add_vertex(0, 1024, 0, 1024, 0, 1024, 0, 0, 0, 12800);
    // box center: flat, clamped, negative and cancelling lights, then one point off the center
    add_vertex(512, 512, 0, 1024, 0, 1024, 25600, 25600, 25600, 25600);
    add_vertex(512, 512, 0, 1024, 0, 1024, 65535, 65535, 65535, 65535);
    add_vertex(512, 512, 0, 1024, 0, 1024, -65536, -65536, -65536, -65536);
    add_vertex(512, 512, 0, 1024, 0, 1024, 25600, -25600, 25600, -25600);
    add_vertex(300, 700, 0, 1024, 0, 1024, 1000, 20000, 40000, 60000);
    // zero width, zero height, all fields at their extremes
    add_vertex(500, 500, 500, 500, 0, 1024, 25600, 25600, 25600, 25600);
    add_vertex(500, 500, 0, 1024, 700, 700, 25600, 25600, 25600, 25600);
    add_vertex(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
               65535, 65535, 65535, 65535);
    add_vertex(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
               -65536, -65536, -65536, -65536);
    // inverted boxes
    add_vertex(256, 512, 1024, 0, 0, 1024, 5000, 10000, 15000, 20000);
    add_vertex(512, 256, 0, 1024, 1024, 0, 5000, 10000, 15000, 20000);
    // far outside, saturating u and v, then the center of the widest box
    add_vertex(8388607, 8388607, 0, 1024, 0, 1024, 25600, 25600, 25600, 25600);
    add_vertex(-8388608, -8388608, 0, 1024, 0, 1024, 25600, 25600, 25600, 25600);
    add_vertex(0, 0, -8388608, 8388607, -8388608, 8388607, 30000, 40000, 50000, 60000);
    // tiny box and points near and past the edges
    add_vertex(101, 100, 100, 101, 100, 101, 0, 40000, 0, 0);
    add_vertex(1100, 512, 0, 1024, 0, 1024, 60000, 20000, 30000, 50000);
    add_vertex(-10, -10, 0, 1024, 0, 1024, 60000, 20000, 30000, 50000);
    add_vertex(-1024, 512, 0, 1024, 0, 1024, 60000, 20000, 30000, 50000);
    add_vertex(1023, 1, 0, 1024, 0, 1024, 65535, 1, 65535, 1);

    run_random(IDLE_NONE, RANDOM_BURST);
    run_random(IDLE_SENDER, RANDOM_BURST);
    run_random(IDLE_RECEIVER, RANDOM_BURST);
    run_random(IDLE_BOTH, RANDOM_BURST);

    while (expected_lights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d vertices under four idle/stall mixes",
             results_checked, vertices_sent);
    $display("degenerate boxes %0d, clamped to full %0d, dark %0d, mismatches %0d",
             seen_degenerate, seen_clamped, seen_zero, errors);
    if (errors == 0)
      $display("[vertex_light_interpolator] OK");
    else
      $display("[vertex_light_interpolator] ERROR");
    $finish;
  end

endmodule
